// ----- rtl/core/hac_pkg.sv -----
// Shared types, constants and CRC table function for the hex-text CRC-16 block.
package hac_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned NibW   = 4;
    localparam int unsigned WordW  = 16;
    localparam int unsigned CrcW   = 16;
    localparam int unsigned PendW  = 12;
    localparam int unsigned CntW   = 2;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned DataW  = 32;

    localparam logic [CrcW-1:0] CrcPoly    = 16'h1021;
    localparam logic [CrcW-1:0] CrcInitRst = 16'hFFFF;
    localparam logic [CntW-1:0] CntFull    = 2'd3;

    // Register index, taken from paddr[2] (registers lie at 4*i).
    localparam logic RegInitialCrc = 1'b0;

    typedef logic [CharW-1:0] t_char;
    typedef logic [NibW-1:0]  t_nibble;
    typedef logic [WordW-1:0] t_word;
    typedef logic [CrcW-1:0]  t_crc;

    // MSB-first table entry for polynomial 0x1021.
    function automatic t_crc crc_table_entry(input logic [7:0] top);
        t_crc r;
        r = {top, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[CrcW-1]) begin
                r = {r[CrcW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                r = {r[CrcW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/hex_ascii_crc16_ccitt.sv -----
// Top level of the hex-text CRC-16 block: input register, word assembly, CRC and result register.
//
// Usage. Characters of a hex-text telegram arrive on the input channel (i_valid,
// o_stall, i_character, i_final_char); a transaction completes at a rising edge with
// i_valid high and o_stall low. Each character is decoded as one hex nibble, four
// nibbles form a word, and each complete word updates the CRC, high byte first.
// On the character flagged final, the CRC appears as one transaction on the output
// channel (o_valid, i_stall, o_crc_value) and the next telegram starts afresh from
// the seed register; a partial word at the end is dropped.
// A character is taken into the input register and processed from there into the
// CRC register, and a result is then presented from the output register. Throughput is
// one character per cycle while no final character waits for the output register.
// When the receiver stalls, the result stays in the output register; characters that
// are not final still flow through, and only a final character waits in the input
// register, raising o_stall, until the output register is free.
// Reset (i_rst_n low, synchronous) empties both registers, sets the seed register to
// FFFF and restarts the telegram. Writing the seed register over the APB port also
// restarts it.
module hex_ascii_crc16_ccitt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Character channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hac_pkg::t_char            i_character,
    input  logic                      i_final_char,
    // Result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output hac_pkg::t_crc             o_crc_value,
    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hac_pkg::AddrW-1:0] paddr,
    input  logic [hac_pkg::DataW-1:0] pwdata,
    output logic [hac_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import hac_pkg::*;

    // Input register
    logic             r_in_valid, n_in_valid;
    t_char            r_in_char,  n_in_char;
    logic             r_in_final, n_in_final;
    // Telegram state
    t_crc             r_init,  n_init;
    t_crc             r_crc,   n_crc;
    logic [PendW-1:0] r_pend,  n_pend;
    logic [CntW-1:0]  r_cnt,   n_cnt;
    // Result register
    logic             r_out_valid, n_out_valid;
    t_crc             r_out_crc,   n_out_crc;

    t_nibble nibble;
    t_crc    crc_word_next;
    t_crc    crc_step;
    logic    out_free;
    logic    advance;
    logic    in_take;
    logic    cfg_we;

    hac_nibble_decode u_decode (
        .i_character (r_in_char),
        .o_nibble    (nibble)
    );

    hac_crc_word u_crc (
        .i_crc  (r_crc),
        .i_word ({r_pend, nibble}),
        .o_crc  (crc_word_next)
    );

    // A final character may only leave the input register once the result register is free.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!r_in_final || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == RegInitialCrc);
    assign prdata = (paddr[2] == RegInitialCrc) ? {{(DataW-CrcW){1'b0}}, r_init} : '0;

    assign crc_step = (r_cnt == CntFull) ? crc_word_next : r_crc;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_char   = r_in_char;
        n_in_final  = r_in_final;
        n_init      = r_init;
        n_crc       = r_crc;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_crc   = r_out_crc;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        if (in_take) begin
            n_in_valid = 1'b1;
            n_in_char  = i_character;
            n_in_final = i_final_char;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        if (advance) begin
            if (r_cnt == CntFull) begin
                n_crc  = crc_word_next;
                n_pend = '0;
                n_cnt  = '0;
            end else begin
                n_pend = {r_pend[PendW-NibW-1:0], nibble};
                n_cnt  = r_cnt + CntW'(1);
            end
            if (r_in_final) begin
                n_out_valid = 1'b1;
                n_out_crc   = crc_step;
                n_crc       = r_init;
                n_pend      = '0;
                n_cnt       = '0;
            end
        end

        // Configuration is to be written only while idle; the block does not enforce it. A write restarts the telegram.
        if (cfg_we) begin
            n_init = pwdata[CrcW-1:0];
            n_crc  = pwdata[CrcW-1:0];
            n_pend = '0;
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_init      <= CrcInitRst;
            r_crc       <= CrcInitRst;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_init      <= n_init;
            r_crc       <= n_crc;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_char  <= n_in_char;
        r_in_final <= n_in_final;
        r_out_crc  <= n_out_crc;
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result register not empty after reset");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(advance && r_in_final))
        else $error("result produced without a final character");

    a_restart_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_final && !cfg_we) |=> (r_cnt == '0 && r_pend == '0
            && r_crc == $past(r_init)))
        else $error("telegram state not restarted after final character");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_in_final && r_out_valid))
        else $error("input stalled without a waiting final character");
`endif

endmodule

// ----- rtl/core/hac_nibble_decode.sv -----
// Decodes one ASCII character into a hex nibble; non-hex characters give zero.
module hac_nibble_decode (
    input  hac_pkg::t_char   i_character,
    output hac_pkg::t_nibble o_nibble
);
    import hac_pkg::*;

    always_comb begin
        if (i_character >= 8'h30 && i_character <= 8'h39) begin
            o_nibble = NibW'(i_character - 8'h30);
        end else if (i_character >= 8'h61 && i_character <= 8'h66) begin
            o_nibble = NibW'(i_character - 8'h57);
        end else if (i_character >= 8'h41 && i_character <= 8'h46) begin
            o_nibble = NibW'(i_character - 8'h37);
        end else begin
            o_nibble = '0;
        end
    end

endmodule

// ----- rtl/core/hac_crc_word.sv -----
// Augmented CRC-16 update over one 16-bit word, high byte first.
module hac_crc_word (
    input  hac_pkg::t_crc  i_crc,
    input  hac_pkg::t_word i_word,
    output hac_pkg::t_crc  o_crc
);
    import hac_pkg::*;

    t_crc crc_mid;

    // Each byte is shifted in at the low end and the entry of the old top byte is folded in.
    assign crc_mid = {i_crc[7:0], i_word[15:8]} ^ crc_table_entry(i_crc[15:8]);
    assign o_crc   = {crc_mid[7:0], i_word[7:0]} ^ crc_table_entry(crc_mid[15:8]);

endmodule

// ----- verif/hac_crc_checker.sv -----
// Checker for the hex-text CRC-16 block: watches both channels and the APB port, predicts and compares.
`timescale 1ns / 1ps

module hac_crc_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_chr_valid,
    input  logic                      i_chr_stall,
    input  hac_pkg::t_char            i_character,
    input  logic                      i_final_char,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  hac_pkg::t_crc             i_crc_value,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [hac_pkg::AddrW-1:0] i_paddr,
    input  logic [hac_pkg::DataW-1:0] i_pwdata,
    input  logic [hac_pkg::DataW-1:0] i_prdata,
    input  logic                      i_pready,
    output int                        o_fail_count,
    output int                        o_crc_waiting
);
    import hac_pkg::*;

    t_crc                ccitt_tab [256];
    t_crc                crc_seed;
    t_crc                crc_run;
    logic [PendW-1:0]    nib_hold;
    logic [CntW-1:0]     nib_cnt;
    t_nibble             nib;
    t_word               word_now;
    t_crc                crc_want;
    t_crc                crc_due [$];
    int                  fail_total = 0;
    int                  due_count  = 0;

    assign o_fail_count  = fail_total;
    assign o_crc_waiting = due_count;

    // Table built bit by bit: entry v is the CRC of byte v from a zero register.
    initial begin
        t_crc e;
        for (int v = 0; v < 256; v++) begin
            e = '0;
            for (int b = 7; b >= 0; b--) begin
                if (e[CrcW-1] ^ v[b]) begin
                    e = {e[CrcW-2:0], 1'b0} ^ CrcPoly;
                end else begin
                    e = {e[CrcW-2:0], 1'b0};
                end
            end
            ccitt_tab[v] = e;
        end
    end

    function automatic t_nibble hex_value(input t_char c);
        if (c >= "0" && c <= "9") return t_nibble'(c - "0");
        if (c >= "a" && c <= "f") return t_nibble'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return t_nibble'(c - "A" + 8'd10);
        return '0;
    endfunction

    function automatic t_crc crc_push_byte(input t_crc crc, input logic [7:0] b);
        return {crc[7:0], b} ^ ccitt_tab[crc[15:8]];
    endfunction

    task automatic restart_telegram();
        crc_run  = crc_seed;
        nib_hold = '0;
        nib_cnt  = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crc_seed = CrcInitRst;
            restart_telegram();
            crc_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (crc_due.size() == 0) begin
                    report_mismatch("crc_value with no result due", '0,
                                    {{(DataW-CrcW){1'b0}}, i_crc_value});
                end else begin
                    crc_want = crc_due.pop_front();
                    if (i_crc_value !== crc_want) begin
                        report_mismatch("crc_value", {{(DataW-CrcW){1'b0}}, crc_want},
                                        {{(DataW-CrcW){1'b0}}, i_crc_value});
                    end
                end
            end
            if (i_chr_valid && !i_chr_stall) begin
                nib = hex_value(i_character);
                if (nib_cnt == CntFull) begin
                    word_now = {nib_hold, nib};
                    crc_run  = crc_push_byte(crc_run, word_now[15:8]);
                    crc_run  = crc_push_byte(crc_run, word_now[7:0]);
                    nib_hold = '0;
                    nib_cnt  = '0;
                end else begin
                    nib_hold = {nib_hold[PendW-NibW-1:0], nib};
                    nib_cnt  = nib_cnt + CntW'(1);
                end
                if (i_final_char) begin
                    crc_due.push_back(crc_run);
                    restart_telegram();
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr[2] == RegInitialCrc) begin
                if (i_pwrite) begin
                    crc_seed = i_pwdata[CrcW-1:0];
                    restart_telegram();
                end else if (i_prdata !== {{(DataW-CrcW){1'b0}}, crc_seed}) begin
                    report_mismatch("seed register read", {{(DataW-CrcW){1'b0}}, crc_seed},
                                    i_prdata);
                end
            end
        end
        due_count <= crc_due.size();
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the hex-text CRC-16 block: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
    import hac_pkg::*;

    // Timing and run length.
    localparam int CycleLimit  = 400000;
    localparam int RandomItems = 1550;
    localparam int Phases      = 8;
    localparam int DrainCycles = 4;

    // Byte addresses on the APB port.
    localparam logic [AddrW-1:0] AddrInitialCrc = 3'd0;
    localparam logic [AddrW-1:0] AddrUnused     = 3'd4;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HOLD,
        STALL_TOGGLE
    } stall_mode_e;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    t_char             i_character  = '0;
    logic              i_final_char = 1'b0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    t_crc              o_crc_value;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [AddrW-1:0]  paddr        = '0;
    logic [DataW-1:0]  pwdata       = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;

    int                fail_count;
    int                crc_waiting;
    int                items_sent   = 0;
    int                burst_left   = 0;
    int                cycle_count  = 0;
    stall_mode_e       stall_mode   = STALL_NONE;
    int                stall_run    = 0;

    hex_ascii_crc16_ccitt u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_character  (i_character),
        .i_final_char (i_final_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_crc_value  (o_crc_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // The checker sits beside the block and sees exactly what the block sees.
    hac_crc_checker u_crc_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_chr_valid   (i_valid),
        .i_chr_stall   (o_stall),
        .i_character   (i_character),
        .i_final_char  (i_final_char),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_crc_value   (o_crc_value),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_crc_waiting (crc_waiting)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // The result receiver stalls in stretches of its own: none at all, random,
    // held solidly for a while, or toggling every cycle. Each stretch is short
    // enough that the watchdog is never threatened.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_run  = $urandom_range(1, 40);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:   i_stall <= 1'b0;
            STALL_RANDOM: i_stall <= 1'($urandom_range(0, 1));
            STALL_HOLD:   i_stall <= 1'b1;
            default:      i_stall <= ~i_stall;
        endcase
    end

    // Mostly hex digits in both cases, with a fair share of arbitrary bytes so
    // that every bit of the character field and non-hex bytes turn up.
    function automatic t_char pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return t_char'("0" + $urandom_range(0, 9));
        if (r < 60) return t_char'("a" + $urandom_range(0, 5));
        if (r < 80) return t_char'("A" + $urandom_range(0, 5));
        return t_char'($urandom_range(0, 255));
    endfunction

    // Presents one character and holds it until the transaction completes. The
    // sender works in bursts: when a burst runs out, a random gap (often none)
    // is inserted with noise on the idle payload, and a new burst length drawn.
    task automatic send_char(input t_char ch, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid      <= 1'b0;
                i_character  <= t_char'($urandom);
                i_final_char <= 1'($urandom);
            end
            burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_character  <= ch;
        i_final_char <= fin;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Sends a literal string, flagging its last character as final if asked.
    task automatic send_text(input string s, input logic fin);
        for (int k = 0; k < s.len(); k++) begin
            send_char(t_char'(s[k]), fin && (k == s.len() - 1));
        end
    endtask

    // Lowers valid and waits until every CRC that is due has come out; then
    // waits on so that characters still inside the block settle before a
    // register write.
    task automatic wait_block_idle();
        @(negedge i_clk);
        i_valid    <= 1'b0;
        burst_left  = 0;
        while (crc_waiting != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // Setup cycle, access cycle, then the bus is released. pready is always
    // high, so the transfer completes at the edge inside the access cycle.
    task automatic apb_access(input logic wr, input logic [AddrW-1:0] a,
                              input logic [DataW-1:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_crc        seed;
        logic [31:0] upper;
        int          phase_end;
        int          len;
        int          r;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of the seed register must read back as all ones.
        apb_access(1'b0, AddrInitialCrc, '0);

        // Directed part, all with the reset seed unless stated.
        // A word made of the digit extremes in both cases, completed by the
        // final character itself.
        send_text("09aF", 1'b1);
        // Non-hex bytes, including those next to each hex range and both
        // byte extremes; all of them decode as zero and still count.
        send_char(8'h00, 1'b0);
        send_text("/:@G", 1'b0);
        send_char(8'h60, 1'b0);
        send_text("g", 1'b0);
        send_char(8'hFF, 1'b1);
        // One complete word followed by a single leftover nibble, which is dropped.
        send_text("ABCDE", 1'b1);
        // A write to an unused address must neither change the seed nor
        // restart the telegram in progress; the telegram ends with no word.
        send_text("1", 1'b0);
        wait_block_idle();
        apb_access(1'b1, AddrUnused, 32'h0000_1234);
        send_text("2", 1'b1);
        // A write to the seed register in mid-telegram throws away what was pending.
        send_text("9f", 1'b0);
        wait_block_idle();
        apb_access(1'b1, AddrInitialCrc, 32'h0000_0000);
        apb_access(1'b0, AddrInitialCrc, '0);
        send_text("5678", 1'b1);

        // Random part, split into phases with a fresh seed each. The first
        // phases use the extremes and the usual CCITT seed.
        for (int p = 0; p < Phases; p++) begin
            wait_block_idle();
            case (p)
                0:       seed = 16'hFFFF;
                1:       seed = 16'h0000;
                2:       seed = 16'h1D0F;
                default: seed = t_crc'($urandom);
            endcase
            upper = $urandom;
            apb_access(1'b1, AddrInitialCrc, {upper[DataW-CrcW-1:0], seed});
            apb_access(1'b0, AddrInitialCrc, '0);

            phase_end = items_sent + RandomItems / Phases;
            while (items_sent < phase_end) begin
                // Mostly whole words, now and then ragged lengths, and
                // occasionally a long telegram. The telegram that reaches the
                // end of the phase is cut short there and flagged final.
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    len = 4 * $urandom_range(1, 6);
                end else if (r < 97) begin
                    len = $urandom_range(1, 30);
                end else begin
                    len = 4 * $urandom_range(20, 50);
                end
                for (int k = 0; k < len && items_sent < phase_end; k++) begin
                    send_char(pick_char(), (k == len - 1) || (items_sent == phase_end - 1));
                end
            end
            // Sometimes leave a telegram unfinished so that the next seed
            // write has something to throw away.
            if ($urandom_range(0, 1) == 1) begin
                len = $urandom_range(1, 7);
                repeat (len) send_char(pick_char(), 1'b0);
            end
        end

        wait_block_idle();
        repeat (2 * DrainCycles) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- hex_ascii_crc16_ccitt.f -----
rtl/core/hac_pkg.sv
rtl/core/hac_nibble_decode.sv
rtl/core/hac_crc_word.sv
rtl/core/hex_ascii_crc16_ccitt.sv
verif/hac_crc_checker.sv
verif/tb.sv
